@@ rtl/c2prm_pkg.sv @@
// constants, widths and the arctangent table for the cartesian to polar radar unit
// no dependencies

package c2prm_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// iterative sections
	localparam int CORDIC_STEPS = 30;
	localparam int ITER_STAGES = 32;
	localparam int DIV_STEPS = 32;

	// datapath widths inside the cordic units
	localparam int VEC_W = 36;
	localparam int VEC_ZW = 34;
	localparam int ROT_W = 33;
	localparam int ROT_ZW = 34;

	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
	localparam logic signed [32:0] RAD_TO_BAM_X4 = 33'sd2734261102;
	localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
	localparam logic signed [18:0] BEARING_LIMIT = 19'sd205888;
	localparam int RANGE_FLOOR_DIV = 1000;

	// arctangent of 2^-i in binary angle units, 2^32 per turn
	localparam logic [29:0] ATAN_BAM [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679806, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81, 30'd41,
		30'd20, 30'd10, 30'd5, 30'd3, 30'd1
	};

endpackage

@@ rtl/cartesian_to_polar_radar_measure_unit.sv @@
// cartesian to polar radar measurement: range, bearing and range rate of one state
// depends on c2prm_pkg for constants and the arctangent table

// Fully pipelined, 73 register stages: one transfer is taken every cycle while the
// output side does not stall. The depth is set by the 32-step square root (run beside
// the two 30-step cordic units) and the 32-step restoring divider for the range rate,
// one step per stage. Each stage holds a valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles close up under stall. min_range is a Q.FRAC_BITS
// floor on the rate divisor, reset to about 0.001; write it only while the pipeline
// is empty.

module cartesian_to_polar_radar_measure_unit #(
	parameter int FRAC_BITS = c2prm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] speed,
	input  logic signed [31:0] heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        range_out,
	output logic signed [18:0] bearing,
	output logic signed [31:0] range_rate
);

	localparam int NIT = c2prm_pkg::ITER_STAGES;
	localparam int NDIV = c2prm_pkg::DIV_STEPS;
	localparam int VW = c2prm_pkg::VEC_W;
	localparam int VZW = c2prm_pkg::VEC_ZW;
	localparam int RW = c2prm_pkg::ROT_W;
	localparam int RZW = c2prm_pkg::ROT_ZW;
	localparam int ST_IT = 3;
	localparam int ST_MUL = ST_IT + NIT + 1;
	localparam int ST_DOT = ST_MUL + 1;
	localparam int ST_NUM = ST_DOT + 1;
	localparam int ST_ABS = ST_NUM + 1;
	localparam int ST_DIV = ST_ABS + 1;
	localparam int NST = ST_DIV + NDIV + 1;
	localparam int MinRangeReset =
		((1 << FRAC_BITS) + c2prm_pkg::RANGE_FLOOR_DIV / 2) / c2prm_pkg::RANGE_FLOOR_DIV;

	// control
	logic [15:0]    min_range_q;
	logic [NST:1]   vld_q;
	logic [NST:1]   vin;
	logic [NST+1:1] rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= 16'(MinRangeReset);
		end else if (cfg_wr_en) begin
			min_range_q <= cfg_wr_data;
		end
	end

	assign rdy[NST+1] = !out_stall;
	for (genvar k = 1; k <= NST; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end
	assign vin = {vld_q[NST-1:1], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (rdy[NST:1] & vin) | (~rdy[NST:1] & vld_q);
		end
	end

	assign in_stall = !rdy[1];
	assign out_valid = vld_q[NST];

	// stage 1: squares, heading scale, magnitudes
	logic signed [31:0] px_s1, py_s1, sp_s1;
	logic [62:0]        sqx_s1, sqy_s1;
	logic signed [63:0] hp_s1;
	logic [31:0]        ax_s1, ay_s1;
	logic signed [63:0] sqx_d, sqy_d, hp_d;

	assign sqx_d = pos_x * pos_x;
	assign sqy_d = pos_y * pos_y;
	assign hp_d = heading * c2prm_pkg::RAD_TO_BAM_X4;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			sp_s1 <= speed;
			sqx_s1 <= sqx_d[62:0];
			sqy_s1 <= sqy_d[62:0];
			hp_s1 <= hp_d;
			ax_s1 <= pos_x[31] ? (~$unsigned(pos_x) + 32'd1) : $unsigned(pos_x);
			ay_s1 <= pos_y[31] ? (~$unsigned(pos_y) + 32'd1) : $unsigned(pos_y);
		end
	end

	// stage 2: sum of squares, binary angle with fold, leading zero count
	logic signed [31:0] px_s2, py_s2, sp_s2;
	logic [63:0]        sum_s2;
	logic signed [31:0] hz_s2;
	logic               flip_s2, nz_s2;
	logic [4:0]         lz_s2;
	logic signed [63:0] hs_d;
	logic [31:0]        bam_d, bamq_d, m_d;
	logic [4:0]         lz_d;

	assign hs_d = hp_s1 + (64'sd1 <<< (FRAC_BITS + 1));
	assign bam_d = hs_d[FRAC_BITS+33:FRAC_BITS+2];
	assign bamq_d = bam_d + 32'h4000_0000;
	assign m_d = (ax_s1 > ay_s1) ? ax_s1 : ay_s1;

	always_comb begin
		lz_d = '0;
		for (int i = 0; i < 32; i++) begin
			if (m_d[i]) lz_d = 5'(31 - i);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			sp_s2 <= sp_s1;
			sum_s2 <= {1'b0, sqx_s1} + {1'b0, sqy_s1};
			flip_s2 <= bamq_d[31];
			hz_s2 <= $signed(bamq_d[31] ? (bam_d ^ 32'h8000_0000) : bam_d);
			nz_s2 <= (px_s1 != 32'sd0) || (py_s1 != 32'sd0);
			lz_s2 <= lz_d;
		end
	end

	// iteration section: index 0 is stage 3, index n is stage 3 + n
	logic [63:0]           sv_s [0:NIT];
	logic [63:0]           sr_s [0:NIT];
	logic signed [VW-1:0]  vx_s [0:NIT];
	logic signed [VW-1:0]  vy_s [0:NIT];
	logic signed [VZW-1:0] vz_s [0:NIT];
	logic signed [RW-1:0]  rx_s [0:NIT];
	logic signed [RW-1:0]  ry_s [0:NIT];
	logic signed [RZW-1:0] rz_s [0:NIT];
	logic signed [31:0]    px_s [0:NIT];
	logic signed [31:0]    py_s [0:NIT];
	logic signed [31:0]    sp_s [0:NIT];
	logic                  flip_s [0:NIT];
	logic                  nz_s [0:NIT];

	// stage 3: normalise and pre-rotate for vectoring, seed rotation and root
	logic signed [VW-1:0] nx_d, ny_d;

	assign nx_d = VW'(px_s2) <<< lz_s2;
	assign ny_d = VW'(py_s2) <<< lz_s2;

	always_ff @(posedge clk) begin
		if (rdy[ST_IT]) begin
			sv_s[0] <= sum_s2;
			sr_s[0] <= '0;
			if (nx_d < 0) begin
				if (ny_d >= 0) begin
					vx_s[0] <= ny_d;
					vy_s[0] <= -nx_d;
					vz_s[0] <= VZW'(34'sd1073741824);
				end else begin
					vx_s[0] <= -ny_d;
					vy_s[0] <= nx_d;
					vz_s[0] <= -VZW'(34'sd1073741824);
				end
			end else begin
				vx_s[0] <= nx_d;
				vy_s[0] <= ny_d;
				vz_s[0] <= '0;
			end
			rx_s[0] <= RW'(c2prm_pkg::CORDIC_GAIN_Q30);
			ry_s[0] <= '0;
			rz_s[0] <= RZW'(hz_s2);
			px_s[0] <= px_s2;
			py_s[0] <= py_s2;
			sp_s[0] <= sp_s2;
			flip_s[0] <= flip_s2;
			nz_s[0] <= nz_s2;
		end
	end

	for (genvar n = 1; n <= NIT; n++) begin : g_iter
		localparam int J = n - 1;
		logic [63:0] bitv, t;
		logic        ge;

		assign bitv = 64'd1 << (62 - 2 * J);
		assign t = sr_s[n-1] + bitv;
		assign ge = sv_s[n-1] >= t;

		always_ff @(posedge clk) begin
			if (rdy[ST_IT+n]) begin
				sv_s[n] <= ge ? (sv_s[n-1] - t) : sv_s[n-1];
				sr_s[n] <= ge ? ((sr_s[n-1] >> 1) + bitv) : (sr_s[n-1] >> 1);
				px_s[n] <= px_s[n-1];
				py_s[n] <= py_s[n-1];
				sp_s[n] <= sp_s[n-1];
				flip_s[n] <= flip_s[n-1];
				nz_s[n] <= nz_s[n-1];
			end
		end

		if (J < c2prm_pkg::CORDIC_STEPS) begin : g_step
			logic signed [VZW-1:0] va;
			logic signed [RZW-1:0] ra;

			assign va = $signed(VZW'(c2prm_pkg::ATAN_BAM[J]));
			assign ra = $signed(RZW'(c2prm_pkg::ATAN_BAM[J]));

			always_ff @(posedge clk) begin
				if (rdy[ST_IT+n]) begin
					if (vy_s[n-1] > 0) begin
						vx_s[n] <= vx_s[n-1] + (vy_s[n-1] >>> J);
						vy_s[n] <= vy_s[n-1] - (vx_s[n-1] >>> J);
						vz_s[n] <= vz_s[n-1] + va;
					end else begin
						vx_s[n] <= vx_s[n-1] - (vy_s[n-1] >>> J);
						vy_s[n] <= vy_s[n-1] + (vx_s[n-1] >>> J);
						vz_s[n] <= vz_s[n-1] - va;
					end
					if (rz_s[n-1] >= 0) begin
						rx_s[n] <= rx_s[n-1] - (ry_s[n-1] >>> J);
						ry_s[n] <= ry_s[n-1] + (rx_s[n-1] >>> J);
						rz_s[n] <= rz_s[n-1] - ra;
					end else begin
						rx_s[n] <= rx_s[n-1] + (ry_s[n-1] >>> J);
						ry_s[n] <= ry_s[n-1] - (rx_s[n-1] >>> J);
						rz_s[n] <= rz_s[n-1] + ra;
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (rdy[ST_IT+n]) begin
					vx_s[n] <= vx_s[n-1];
					vy_s[n] <= vy_s[n-1];
					vz_s[n] <= vz_s[n-1];
					rx_s[n] <= rx_s[n-1];
					ry_s[n] <= ry_s[n-1];
					rz_s[n] <= rz_s[n-1];
				end
			end
		end
	end

	// products for bearing scale and projection
	logic signed [65:0] bp_sm;
	logic signed [64:0] cx_sm, cy_sm;
	logic signed [31:0] sp_sm;
	logic [31:0]        rng_sm;
	logic               flip_sm, nz_sm;
	logic signed [65:0] bp_d;
	logic signed [64:0] cx_d, cy_d;

	assign bp_d = vz_s[NIT] * c2prm_pkg::PI_Q29;
	assign cx_d = px_s[NIT] * rx_s[NIT];
	assign cy_d = py_s[NIT] * ry_s[NIT];

	always_ff @(posedge clk) begin
		if (rdy[ST_MUL]) begin
			bp_sm <= bp_d;
			cx_sm <= cx_d;
			cy_sm <= cy_d;
			sp_sm <= sp_s[NIT];
			rng_sm <= sr_s[NIT][31:0];
			flip_sm <= flip_s[NIT];
			nz_sm <= nz_s[NIT];
		end
	end

	// dot product rounding, bearing rounding and clamp, divisor
	logic signed [33:0] dot_sd;
	logic signed [31:0] sp_sd;
	logic [31:0]        rng_sd, dv_sd;
	logic signed [18:0] brg_sd;
	logic signed [65:0] ds_d, dn_d, dt_d, br_d;
	logic [31:0]        dm_d;
	logic signed [18:0] bc_d;

	assign ds_d = 66'(cx_sm) + 66'(cy_sm);
	assign dn_d = flip_sm ? -ds_d : ds_d;
	assign dt_d = (dn_d + 66'sd536870912) >>> 30;
	assign br_d = (bp_sm + (66'sd1 <<< 43)) >>> 44;
	assign dm_d = (rng_sm > 32'(min_range_q)) ? rng_sm : 32'(min_range_q);

	always_comb begin
		if (!nz_sm) begin
			bc_d = '0;
		end else if (br_d > 66'(c2prm_pkg::BEARING_LIMIT)) begin
			bc_d = c2prm_pkg::BEARING_LIMIT;
		end else if (br_d < -66'(c2prm_pkg::BEARING_LIMIT)) begin
			bc_d = -c2prm_pkg::BEARING_LIMIT;
		end else begin
			bc_d = br_d[18:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[ST_DOT]) begin
			dot_sd <= dt_d[33:0];
			sp_sd <= sp_sm;
			rng_sd <= rng_sm;
			dv_sd <= (dm_d == 32'd0) ? 32'd1 : dm_d;
			brg_sd <= bc_d;
		end
	end

	// numerator
	logic signed [65:0] num_sn;
	logic [31:0]        rng_sn, dv_sn;
	logic signed [18:0] brg_sn;
	logic signed [65:0] num_d;

	assign num_d = dot_sd * sp_sd;

	always_ff @(posedge clk) begin
		if (rdy[ST_NUM]) begin
			num_sn <= num_d;
			rng_sn <= rng_sd;
			dv_sn <= dv_sd;
			brg_sn <= brg_sd;
		end
	end

	// magnitude and sign
	logic [65:0]        mag_sa;
	logic               neg_sa;
	logic [31:0]        rng_sa, dv_sa;
	logic signed [18:0] brg_sa;

	always_ff @(posedge clk) begin
		if (rdy[ST_ABS]) begin
			mag_sa <= num_sn[65] ? $unsigned(-num_sn) : $unsigned(num_sn);
			neg_sa <= num_sn[65];
			rng_sa <= rng_sn;
			dv_sa <= dv_sn;
			brg_sa <= brg_sn;
		end
	end

	// divider section: index 0 is the overflow check, then one quotient bit a stage
	logic [31:0]        dr_s [0:NDIV];
	logic [31:0]        lo_s [0:NDIV];
	logic [31:0]        q_s [0:NDIV];
	logic               ovf_s [0:NDIV];
	logic               neg_s [0:NDIV];
	logic [31:0]        dv_s [0:NDIV];
	logic [31:0]        rng_s [0:NDIV];
	logic signed [18:0] brg_s [0:NDIV];

	always_ff @(posedge clk) begin
		if (rdy[ST_DIV]) begin
			dr_s[0] <= mag_sa[63:32];
			lo_s[0] <= mag_sa[31:0];
			q_s[0] <= '0;
			ovf_s[0] <= mag_sa[65:32] >= {2'b00, dv_sa};
			neg_s[0] <= neg_sa;
			dv_s[0] <= dv_sa;
			rng_s[0] <= rng_sa;
			brg_s[0] <= brg_sa;
		end
	end

	for (genvar n = 1; n <= NDIV; n++) begin : g_div
		logic [32:0] r2;
		logic        qb;

		assign r2 = {dr_s[n-1], lo_s[n-1][31]};
		assign qb = r2 >= {1'b0, dv_s[n-1]};

		always_ff @(posedge clk) begin
			if (rdy[ST_DIV+n]) begin
				dr_s[n] <= qb ? 32'(r2 - {1'b0, dv_s[n-1]}) : r2[31:0];
				lo_s[n] <= lo_s[n-1] << 1;
				q_s[n] <= {q_s[n-1][30:0], qb};
				ovf_s[n] <= ovf_s[n-1];
				neg_s[n] <= neg_s[n-1];
				dv_s[n] <= dv_s[n-1];
				rng_s[n] <= rng_s[n-1];
				brg_s[n] <= brg_s[n-1];
			end
		end
	end

	// output stage with saturation
	logic [31:0] rate_d;

	always_comb begin
		if (neg_s[NDIV]) begin
			if (ovf_s[NDIV] || (q_s[NDIV] > 32'h8000_0000)) begin
				rate_d = 32'h8000_0000;
			end else begin
				rate_d = ~q_s[NDIV] + 32'd1;
			end
		end else begin
			if (ovf_s[NDIV] || (q_s[NDIV] > 32'h7FFF_FFFF)) begin
				rate_d = 32'h7FFF_FFFF;
			end else begin
				rate_d = q_s[NDIV];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST]) begin
			range_out <= rng_s[NDIV];
			bearing <= brg_s[NDIV];
			range_rate <= $signed(rate_d);
		end
	end

endmodule

@@ verif/cartesian_to_polar_radar_measure_unit_tb.sv @@
// testbench for cartesian_to_polar_radar_measure_unit: range, bearing and range rate
// checked against a bit-exact predictor under random idling and stalls and several floor settings
// depends on c2prm_pkg and the unit under test
`timescale 1ns / 100ps

module cartesian_to_polar_radar_measure_unit_tb;

	typedef struct packed {
		logic [31:0]        rng;
		logic signed [18:0] brg;
		logic signed [31:0] rate;
	} polar_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [15:0]        cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] speed;
	logic signed [31:0] heading;
	logic               out_valid;
	logic               out_stall;
	logic [31:0]        range_out;
	logic signed [18:0] bearing;
	logic signed [31:0] range_rate;

	polar_t      pending_q[$];
	logic [15:0] floor_reg;
	int          send_idle_pct;
	int          stall_pct;
	int          errors;
	int          items_sent;
	int          results_seen;

	cartesian_to_polar_radar_measure_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.speed(speed),
		.heading(heading),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.range_out(range_out),
		.bearing(bearing),
		.range_rate(range_rate)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint vector_bam(longint x, longint y);
		longint z;
		longint t;
		longint xs;
		longint ys;
		longint unsigned m;
		z = 0;
		m = (x < 0) ? -x : x;
		if (((y < 0) ? -y : y) > m)
			m = (y < 0) ? -y : y;
		while (m < 64'h8000_0000) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 1073741824;
			end else begin
				x = -y;
				y = t;
				z = -1073741824;
			end
		end
		for (int i = 0; i < c2prm_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(c2prm_pkg::ATAN_BAM[i]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(c2prm_pkg::ATAN_BAM[i]);
			end
		end
		return z;
	endfunction

	function automatic void rotate_unit(input logic [31:0] bam, output longint c,
			output longint s);
		logic [31:0] folded;
		logic        flip;
		longint      x;
		longint      y;
		longint      z;
		longint      xs;
		longint      ys;
		folded = bam + 32'h4000_0000;
		flip = folded[31];
		if (flip)
			bam = bam ^ 32'h8000_0000;
		x = longint'(c2prm_pkg::CORDIC_GAIN_Q30);
		y = 0;
		z = longint'(signed'(bam));
		for (int i = 0; i < c2prm_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(c2prm_pkg::ATAN_BAM[i]);
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(c2prm_pkg::ATAN_BAM[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic polar_t measure(logic signed [31:0] px32, logic signed [31:0] py32,
			logic signed [31:0] sp32, logic signed [31:0] hd32);
		polar_t          res;
		longint          px;
		longint          py;
		longint          sp;
		longint          brg;
		longint          c;
		longint          s;
		longint          dot;
		longint          num;
		longint unsigned rng;
		longint unsigned d;
		longint unsigned mag;
		longint unsigned q;
		logic [63:0]     prod;
		px = px32;
		py = py32;
		sp = sp32;
		rng = isqrt(longint'(px * px) + longint'(py * py));
		brg = 0;
		if (px != 0 || py != 0) begin
			brg = (vector_bam(px, py) * longint'(c2prm_pkg::PI_Q29) + (64'sd1 <<< 43)) >>> 44;
			if (brg > c2prm_pkg::BEARING_LIMIT)
				brg = c2prm_pkg::BEARING_LIMIT;
			if (brg < -c2prm_pkg::BEARING_LIMIT)
				brg = -c2prm_pkg::BEARING_LIMIT;
		end
		prod = {{32{hd32[31]}}, hd32} * 64'd2734261102 + (64'd1 << 17);
		rotate_unit(prod[49:18], c, s);
		dot = (px * c + py * s + (64'sd1 <<< 29)) >>> 30;
		num = dot * sp;
		d = (rng > floor_reg) ? rng : floor_reg;
		if (d == 0)
			d = 1;
		mag = (num < 0) ? -num : num;
		q = mag / d;
		res.rng = rng[31:0];
		res.brg = brg[18:0];
		if (num < 0) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			res.rate = 32'(-q);
		end else begin
			if (q > 64'h7FFF_FFFF)
				q = 64'h7FFF_FFFF;
			res.rate = q[31:0];
		end
		return res;
	endfunction

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		polar_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (range_out !== want.rng) begin
					$error("range_out expected %0d actual %0d", want.rng, range_out);
					errors++;
				end
				if (bearing !== want.brg) begin
					$error("bearing expected %0d actual %0d", want.brg, bearing);
					errors++;
				end
				if (range_rate !== want.rate) begin
					$error("range_rate expected %0d actual %0d", want.rate, range_rate);
					errors++;
				end
			end
		end
	end

	task automatic send_state(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] sp, input logic [31:0] hd);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			pos_x <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		speed <= sp;
		heading <= hd;
		do
			@(posedge clk);
		while (in_stall);
		pending_q.push_back(measure(px, py, sp, hd));
		items_sent++;
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_floor(input logic [15:0] v);
		go_quiet();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		floor_reg = v;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'(int'($urandom_range(400)) - 200);
			2: return 32'(int'($urandom_range(2_000_000)) - 1_000_000);
			3: return 32'(int'($urandom_range(200_000_000)) - 100_000_000);
			4: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
			                            : 32'h8000_0000 + $urandom_range(3);
			default: return 32'(int'($urandom_range(40)) - 20);
		endcase
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_state(rand_coord(), rand_coord(), rand_coord(),
				$urandom_range(1) ? $urandom : 32'(int'($urandom_range(900_000)) - 450_000));
	endtask

	task automatic test_directed();
		send_state(0, 0, 32'h0001_0000, 0);
		send_state(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_state(32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
		send_state(32'h8000_0000, 1, 32'h8000_0000, 205887);
		send_state(32'h8000_0000, -1, 32'h8000_0000, -205887);
		send_state(-65536, 65536, 65536, 102944);
		send_state(-65536, -65536, 65536, -102944);
		send_state(0, 65536, 65536, 102944);
		send_state(0, -65536, -65536, -102944);
		send_state(65536, 0, 65536, 411775);
		send_state(1, 0, 32'h8000_0000, 0);
		send_state(-1, 0, 32'h7FFF_FFFF, 205887);
		send_state(30, -40, 32'h7FFF_FFFF, 1000);
		send_state(66, 0, 32'h8000_0000, 0);
		send_state(65, 10, 32'h7FFF_FFFF, -3);
		send_state(-32'sd1, -32'sd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_state(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		send_state(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	task automatic test_floor_settings();
		logic [15:0] floors[5] = '{16'd1, 16'd65535, 16'd0, 16'd1000, 16'd66};
		foreach (floors[k]) begin
			write_floor(floors[k]);
			send_state(0, 0, 32'h7FFF_FFFF, 0);
			send_state(1, 0, 32'h8000_0000, 0);
			send_state(40, -30, 32'h7FFF_FFFF, 205887);
			send_random(20);
		end
	endtask

	task automatic test_idling_phases();
		int pct[4][2] = '{'{0, 0}, '{80, 0}, '{0, 80}, '{13, 13}};
		foreach (pct[k]) begin
			send_idle_pct = pct[k][0];
			stall_pct = pct[k][1];
			send_random(190);
		end
	endtask

	task automatic test_drain_pause();
		send_idle_pct = 13;
		stall_pct = 13;
		send_random(40);
		go_quiet();
		send_random(40);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		speed = '0;
		heading = '0;
		out_stall = 1'b0;
		floor_reg = 16'd66;
		send_idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_drain_pause();
		test_idling_phases();
		test_floor_settings();
		go_quiet();
		$display("covered %0d transfers in, %0d results out, floors 0/1/66/1000/65535,",
			items_sent, results_seen);
		$display("idle and stall mixes of 0, 13 and 80 percent");
		if (errors == 0)
			$display("cartesian_to_polar_radar_measure_unit_tb passed");
		else
			$display("cartesian_to_polar_radar_measure_unit_tb failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("cartesian_to_polar_radar_measure_unit_tb failed");
		$finish;
	end

endmodule
